>>> hw/rtl/skl_pkg.sv
// Shared types and codes for the sorted key list.
`timescale 1ns / 1ps
package skl_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BYTES_DEF = 4;
    localparam int KEY_PORT_W    = 32;

    // Operation codes on the input beat
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_DUMP   = 2'd2;

    // Status codes on the result beat
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    // Per-cell compare results seen by the neighbors and the controller
    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

>>> hw/rtl/skl_cell.sv
// One slot of the sorted chain: holds a key and its valid bit.
`timescale 1ns / 1ps
module skl_cell #(
    parameter int KEY_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  skl_pkg::cell_op_t     op,
    input  logic [KEY_W-1:0]      new_key,
    input  logic [KEY_W-1:0]      left_key,
    input  skl_pkg::cell_flags_t  left_flags,
    input  logic [KEY_W-1:0]      right_key,
    input  logic                  right_valid,
    output logic [KEY_W-1:0]      key,
    output skl_pkg::cell_flags_t  flags
);
    import skl_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             valid_reg, valid_next;

    assign flags.valid = valid_reg;
    assign flags.lt    = valid_reg && (key_reg < new_key);
    assign flags.eq    = valid_reg && (key_reg == new_key);
    assign key         = key_reg;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (op)
            CELL_INSERT: begin
                // cells below the insert point stay; the rest shift up by one
                if (!flags.lt) begin
                    key_next   = left_flags.lt ? new_key : left_key;
                    valid_next = valid_reg | left_flags.valid;
                end
            end
            CELL_REMOVE: begin
                // from the first matching key on, pull from the right
                if (valid_reg && !flags.lt) begin
                    key_next   = right_key;
                    valid_next = right_valid;
                end
            end
            CELL_ROTATE: begin
                key_next   = right_key;
                valid_next = right_valid;
            end
            default: begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

endmodule

>>> hw/rtl/sorted_key_list_top.sv
// Top level of the sorted key list: cell chain, command control and result register.
// Insert and remove: the result beat is registered in the cycle after the command is accepted.
// Dump: no command is accepted while the chain rotates once through all DEPTH cells,
//   one key leaving cell 0 per cycle, stalled only while a result beat waits.
// An empty dump answers with one DONE beat; unused code 3 is consumed with no result.
// Reset (aresetn low, synchronous) clears the count, the cell valid bits and the
//   output valid; stored key values are not reset.
`timescale 1ns / 1ps
module sorted_key_list_top #(
    parameter int DEPTH     = skl_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = skl_pkg::KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], key_value[33:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], has_value[2], stored_key[34:3], zero fill
    output logic        m_tlast    // is_last
);
    import skl_pkg::*;

    // Keys wider than the port carry zero upper bytes, so the compare stays 32 bits.
    localparam int KEY_W = (KEY_BYTES * 8 > KEY_PORT_W) ? KEY_PORT_W : KEY_BYTES * 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t state_reg, state_next;

    // ---- input beat decode ----
    logic [1:0]       in_func;
    logic [KEY_W-1:0] in_key;
    logic             s_accept;

    assign in_func  = s_tdata[1:0];
    assign in_key   = s_tdata[2 +: KEY_W];
    assign s_accept = s_tvalid && s_tready;

    // ---- cell chain ----
    logic [KEY_W-1:0] cell_key   [DEPTH];
    cell_flags_t      cell_flags [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] eq_vec;
    cell_op_t         cell_op;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] lkey, rkey;
        cell_flags_t      lflags;
        logic             rvalid;

        if (i == 0) begin : g_first
            // cell 0 has an imaginary valid, less-than neighbor on its left,
            // so a key not above cell 0 lands in cell 0
            assign lkey   = '0;
            assign lflags = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
        end else begin : g_inner
            assign lkey   = cell_key[i-1];
            assign lflags = cell_flags[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            // wraps to cell 0 for the dump rotation, empty slot otherwise
            assign rkey   = cell_key[0];
            assign rvalid = (cell_op == CELL_ROTATE) ? cell_flags[0].valid : 1'b0;
        end else begin : g_mid
            assign rkey   = cell_key[i+1];
            assign rvalid = cell_flags[i+1].valid;
        end

        assign valid_vec[i] = cell_flags[i].valid;
        assign eq_vec[i]    = cell_flags[i].eq;

        skl_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (cell_op),
            .new_key     (in_key),
            .left_key    (lkey),
            .left_flags  (lflags),
            .right_key   (rkey),
            .right_valid (rvalid),
            .key         (cell_key[i]),
            .flags       (cell_flags[i])
        );
    end

    // ---- control ----
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             store_full;
    logic             key_found;
    logic             out_free;
    logic             dump_emit;
    logic             dump_step;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic                  out_has_reg, out_has_next;
    logic [KEY_PORT_W-1:0] out_key_reg, out_key_next;
    logic                  out_last_reg, out_last_next;

    assign store_full = (count_reg == CNT_W'(DEPTH));
    assign key_found  = |eq_vec;
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;

    // during a dump, cell 0 carries the next key in order; slots past the count only rotate
    assign dump_emit = (CNT_W'(idx_reg) < count_reg);
    assign dump_step = (state_reg == ST_DUMP) && (!dump_emit || out_free);

    always_comb begin
        cell_op         = CELL_HOLD;
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_has_next    = out_has_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_func)
                        FUNC_INSERT: begin
                            out_valid_next  = 1'b1;
                            out_has_next    = 1'b0;
                            out_key_next    = '0;
                            out_last_next   = 1'b1;
                            if (store_full) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                out_status_next = STATUS_DONE;
                                cell_op         = CELL_INSERT;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            out_valid_next  = 1'b1;
                            out_has_next    = 1'b0;
                            out_key_next    = '0;
                            out_last_next   = 1'b1;
                            if (key_found) begin
                                out_status_next = STATUS_DONE;
                                cell_op         = CELL_REMOVE;
                                count_next      = count_reg - CNT_W'(1);
                            end else begin
                                out_status_next = STATUS_MISSING;
                            end
                        end
                        FUNC_DUMP: begin
                            if (count_reg == '0) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_DONE;
                                out_has_next    = 1'b0;
                                out_key_next    = '0;
                                out_last_next   = 1'b1;
                            end else begin
                                state_next = ST_DUMP;
                                idx_next   = '0;
                            end
                        end
                        default: begin
                            // unused code: beat is consumed, nothing happens
                            cell_op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (dump_step) begin
                    cell_op = CELL_ROTATE;
                    if (dump_emit) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_DONE;
                        out_has_next    = 1'b1;
                        out_key_next    = KEY_PORT_W'(cell_key[0]);
                        out_last_next   = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
                    end
                    if (idx_reg == IDX_W'(DEPTH - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_status_reg <= out_status_next;
        out_has_reg    <= out_has_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_key_reg, out_has_reg, out_status_reg};

    // ---- assertions ----

    // count never exceeds the chain length
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // outside a dump the number of valid cells equals the entry count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("valid bits disagree with entry count");

    // an insert into a full store leaves the count alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_func == FUNC_INSERT && store_full) |=> (count_reg == $past(count_reg)))
        else $error("count changed on full insert");

endmodule
